/* hw/rtl/bqm_pkg.sv */
// Package for the bilinear quadrilateral map: widths, register indexes, types
// and the rounding and saturation helpers. Depends on nothing; every other file
// in hw/rtl imports it.
package bqm_pkg;

	// Number formats
	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int REF_WIDTH   = FRAC_BITS + 1;
	localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
	localparam int EDGE_WIDTH  = COORD_WIDTH + 2;
	localparam int JAC_WIDTH   = COORD_WIDTH + FRAC_BITS + 4;
	localparam int PNT_WIDTH   = COORD_WIDTH + 2 * FRAC_BITS + 6;

	// Configuration registers and pipeline depth
	localparam int NUM_REGS      = 8;
	localparam int REG_IDX_WIDTH = $clog2(NUM_REGS);
	localparam int PIPE_DEPTH    = 5;

	localparam logic [REG_IDX_WIDTH-1:0] REG_C0_X = REG_IDX_WIDTH'(0);
	localparam logic [REG_IDX_WIDTH-1:0] REG_C0_Y = REG_IDX_WIDTH'(1);
	localparam logic [REG_IDX_WIDTH-1:0] REG_C1_X = REG_IDX_WIDTH'(2);
	localparam logic [REG_IDX_WIDTH-1:0] REG_C1_Y = REG_IDX_WIDTH'(3);
	localparam logic [REG_IDX_WIDTH-1:0] REG_C2_X = REG_IDX_WIDTH'(4);
	localparam logic [REG_IDX_WIDTH-1:0] REG_C2_Y = REG_IDX_WIDTH'(5);
	localparam logic [REG_IDX_WIDTH-1:0] REG_C3_X = REG_IDX_WIDTH'(6);
	localparam logic [REG_IDX_WIDTH-1:0] REG_C3_Y = REG_IDX_WIDTH'(7);

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic [REF_WIDTH-1:0]          ref_t;
	typedef logic signed [JAC_WIDTH-1:0]   jac_t;
	typedef logic signed [PNT_WIDTH-1:0]   pnt_t;

	// Constants in the coordinate and reference formats
	localparam ref_t   REF_ONE    = REF_WIDTH'(1) << FRAC_BITS;
	localparam coord_t COORD_ZERO = '0;
	localparam coord_t COORD_ONE  = COORD_WIDTH'(1) << FRAC_BITS;
	localparam coord_t COORD_MAX  = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
	localparam coord_t COORD_MIN  = {1'b1, {(COORD_WIDTH - 1){1'b0}}};
	localparam jac_t   JAC_HALF   = JAC_WIDTH'(1) << (FRAC_BITS - 1);
	localparam pnt_t   PNT_HALF   = PNT_WIDTH'(1) << (2 * FRAC_BITS - 1);

	// Per-axis coefficients derived from the corners:
	// a = c1 - c0, b = c3 - c0, e = c0 - c1 + c2 - c3.
	typedef struct packed {
		coord_t                        c0;
		logic signed [DIFF_WIDTH-1:0]  a;
		logic signed [DIFF_WIDTH-1:0]  b;
		logic signed [EDGE_WIDTH-1:0]  e;
	} axis_coef_t;

	// Rounded and saturated value with its clip flag.
	typedef struct packed {
		coord_t value;
		logic   sat;
	} rnd_t;

	// Per-axis results: the mapped coordinate and the two Jacobian entries.
	typedef struct packed {
		coord_t point;
		coord_t d_dxi;
		coord_t d_deta;
		logic   pnt_sat;
		logic   jac_sat;
	} axis_res_t;

	// Coefficients of one axis from its four corner values.
	function automatic axis_coef_t derive_coef(input coord_t c0, input coord_t c1,
			input coord_t c2, input coord_t c3);
		axis_coef_t r;
		r.c0 = c0;
		r.a  = DIFF_WIDTH'(c1) - DIFF_WIDTH'(c0);
		r.b  = DIFF_WIDTH'(c3) - DIFF_WIDTH'(c0);
		r.e  = EDGE_WIDTH'(c0) - EDGE_WIDTH'(c1) + EDGE_WIDTH'(c2) - EDGE_WIDTH'(c3);
		return r;
	endfunction

	// Reference coordinates above 1.0 are clipped to 1.0.
	function automatic ref_t clamp_ref(input ref_t v);
		return (v > REF_ONE) ? REF_ONE : v;
	endfunction

	// Round a Jacobian sum to nearest (ties up), then saturate to a coordinate.
	function automatic rnd_t round_jac(input jac_t v);
		jac_t sum;
		jac_t sh;
		rnd_t r;
		sum = v + JAC_HALF;
		sh  = sum >>> FRAC_BITS;
		if (sh == {{(JAC_WIDTH - COORD_WIDTH){sh[COORD_WIDTH-1]}}, sh[COORD_WIDTH-1:0]}) begin
			r.value = sh[COORD_WIDTH-1:0];
			r.sat   = 1'b0;
		end else begin
			r.value = sh[JAC_WIDTH-1] ? COORD_MIN : COORD_MAX;
			r.sat   = 1'b1;
		end
		return r;
	endfunction

	// Round a point sum (two fraction scalings) to nearest, then saturate.
	function automatic rnd_t round_pnt(input pnt_t v);
		pnt_t sum;
		pnt_t sh;
		rnd_t r;
		sum = v + PNT_HALF;
		sh  = sum >>> (2 * FRAC_BITS);
		if (sh == {{(PNT_WIDTH - COORD_WIDTH){sh[COORD_WIDTH-1]}}, sh[COORD_WIDTH-1:0]}) begin
			r.value = sh[COORD_WIDTH-1:0];
			r.sat   = 1'b0;
		end else begin
			r.value = sh[PNT_WIDTH-1] ? COORD_MIN : COORD_MAX;
			r.sat   = 1'b1;
		end
		return r;
	endfunction

endpackage

/* hw/rtl/bqm_cfg.sv */
// Corner register file of the quadrilateral map and the registered per-axis
// coefficients derived from it. Depends on bqm_pkg.
module bqm_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [bqm_pkg::REG_IDX_WIDTH-1:0]    cfg_idx,
	input  logic [bqm_pkg::COORD_WIDTH-1:0]      cfg_wdata,
	output bqm_pkg::axis_coef_t                  coef_x,
	output bqm_pkg::axis_coef_t                  coef_y
);
	import bqm_pkg::*;

	coord_t     corner_q [NUM_REGS];
	axis_coef_t coef_x_q;
	axis_coef_t coef_y_q;

	// Corner registers: one write transfer per enabled cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q[REG_C0_X] <= COORD_ZERO;
			corner_q[REG_C0_Y] <= COORD_ZERO;
			corner_q[REG_C1_X] <= COORD_ONE;
			corner_q[REG_C1_Y] <= COORD_ZERO;
			corner_q[REG_C2_X] <= COORD_ONE;
			corner_q[REG_C2_Y] <= COORD_ONE;
			corner_q[REG_C3_X] <= COORD_ZERO;
			corner_q[REG_C3_Y] <= COORD_ONE;
		end else if (cfg_we) begin
			corner_q[cfg_idx] <= cfg_wdata;
		end
	end

	// Derived coefficients follow the corners in the next cycle; an item needs
	// them only from its second stage on, so a write just before a start is seen.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_x_q <= derive_coef(COORD_ZERO, COORD_ONE, COORD_ONE, COORD_ZERO);
			coef_y_q <= derive_coef(COORD_ZERO, COORD_ZERO, COORD_ONE, COORD_ONE);
		end else begin
			coef_x_q <= derive_coef(corner_q[REG_C0_X], corner_q[REG_C1_X],
				corner_q[REG_C2_X], corner_q[REG_C3_X]);
			coef_y_q <= derive_coef(corner_q[REG_C0_Y], corner_q[REG_C1_Y],
				corner_q[REG_C2_Y], corner_q[REG_C3_Y]);
		end
	end

	assign coef_x = coef_x_q;
	assign coef_y = coef_y_q;

endmodule

/* hw/rtl/bqm_axis.sv */
// Arithmetic pipeline of one coordinate axis: mapped point and the two Jacobian
// entries, stages two to five. Depends on bqm_pkg.
module bqm_axis (
	input  logic                clk,
	input  bqm_pkg::ref_t       xi_s1,
	input  bqm_pkg::ref_t       eta_s1,
	input  bqm_pkg::axis_coef_t coef,
	output bqm_pkg::axis_res_t  res_s5
);
	import bqm_pkg::*;

	jac_t xe_s2;
	jac_t ee_s2;
	jac_t xa_s2;
	ref_t eta_s2;
	jac_t deta_s3;
	jac_t dxi_s3;
	jac_t xa_s3;
	ref_t eta_s3;
	pnt_t et_s4;
	pnt_t base_s4;
	rnd_t jxi_s4;
	rnd_t jeta_s4;
	rnd_t pnt_rnd;
	axis_res_t res_q_s5;

	// Stage 2: products of the reference coordinates with the edge terms.
	always_ff @(posedge clk) begin
		xe_s2  <= JAC_WIDTH'($signed({1'b0, xi_s1}) * coef.e);
		ee_s2  <= JAC_WIDTH'($signed({1'b0, eta_s1}) * coef.e);
		xa_s2  <= JAC_WIDTH'($signed({1'b0, xi_s1}) * coef.a);
		eta_s2 <= eta_s1;
	end

	// Stage 3: unrounded Jacobian entries, scaled by one fraction.
	always_ff @(posedge clk) begin
		deta_s3 <= (JAC_WIDTH'(coef.b) <<< FRAC_BITS) + xe_s2;
		dxi_s3  <= (JAC_WIDTH'(coef.a) <<< FRAC_BITS) + ee_s2;
		xa_s3   <= xa_s2;
		eta_s3  <= eta_s2;
	end

	// Stage 4: eta times d/deta completes the bilinear term of the point;
	// the Jacobian entries are rounded here.
	always_ff @(posedge clk) begin
		et_s4   <= PNT_WIDTH'($signed({1'b0, eta_s3}) * deta_s3);
		base_s4 <= (PNT_WIDTH'(coef.c0) <<< (2 * FRAC_BITS))
			+ (PNT_WIDTH'(xa_s3) <<< FRAC_BITS);
		jxi_s4  <= round_jac(dxi_s3);
		jeta_s4 <= round_jac(deta_s3);
	end

	// Stage 5: point sum, rounding and the result register.
	assign pnt_rnd = round_pnt(base_s4 + et_s4);

	always_ff @(posedge clk) begin
		res_q_s5.point   <= pnt_rnd.value;
		res_q_s5.pnt_sat <= pnt_rnd.sat;
		res_q_s5.d_dxi   <= jxi_s4.value;
		res_q_s5.d_deta  <= jeta_s4.value;
		res_q_s5.jac_sat <= jxi_s4.sat | jeta_s4.sat;
	end

	assign res_s5 = res_q_s5;

endmodule

/* hw/rtl/bilinear_quad_map_with_jacobian_top.sv */
// Top level of the bilinear quadrilateral map with Jacobian.
// Depends on bqm_pkg, bqm_cfg and bqm_axis.
//
// Usage: the four corners are written through cfg_we / cfg_idx / cfg_wdata,
// one register per cycle, indexes 0..7 in the order x0, y0, x1, y1, x2, y2,
// x3, y3 (signed Q16.16). Corners must be changed only while no point is in
// flight; the block does not enforce this. A point (ref_xi, ref_eta,
// unsigned 1.16, values above 1.0 clipped to 1.0) is transferred at each
// rising edge where start is high and busy is low. busy is always low: the
// five-stage pipeline takes a new point every cycle, so the sustained rate
// is one point per clock. A result appears on phys_x, phys_y and the four
// Jacobian ports with done high for exactly one cycle; the depth is set by
// the two multiply stages of the per-axis datapath and the rounding stages.
// The receiver cannot stall, so each result must be taken when done is high.
// saturated is high if the point or any Jacobian entry of a result was clipped.
// Reset clears the pipeline valid bits and loads the unit-square corners.
module bilinear_quad_map_with_jacobian_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [bqm_pkg::REF_WIDTH-1:0]        ref_xi,
	input  logic [bqm_pkg::REF_WIDTH-1:0]        ref_eta,
	input  logic                                 cfg_we,
	input  logic [bqm_pkg::REG_IDX_WIDTH-1:0]    cfg_idx,
	input  logic [bqm_pkg::COORD_WIDTH-1:0]      cfg_wdata,
	output logic                                 done,
	output logic signed [bqm_pkg::COORD_WIDTH-1:0] phys_x,
	output logic signed [bqm_pkg::COORD_WIDTH-1:0] phys_y,
	output logic signed [bqm_pkg::COORD_WIDTH-1:0] jac_dx_dxi,
	output logic signed [bqm_pkg::COORD_WIDTH-1:0] jac_dx_deta,
	output logic signed [bqm_pkg::COORD_WIDTH-1:0] jac_dy_dxi,
	output logic signed [bqm_pkg::COORD_WIDTH-1:0] jac_dy_deta,
	output logic                                 saturated
);
	import bqm_pkg::*;

	logic       accept;
	logic       valid_s1;
	logic       valid_s2;
	logic       valid_s3;
	logic       valid_s4;
	logic       valid_s5;
	ref_t       xi_s1;
	ref_t       eta_s1;
	axis_coef_t coef_x;
	axis_coef_t coef_y;
	axis_res_t  res_x_s5;
	axis_res_t  res_y_s5;

	// The pipeline never stalls, so a transfer is taken in every cycle with start high.
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// Valid bits travel alongside the datapath stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// Stage 1: clipped reference point.
	always_ff @(posedge clk) begin
		if (accept) begin
			xi_s1  <= clamp_ref(ref_xi);
			eta_s1 <= clamp_ref(ref_eta);
		end
	end

	bqm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.coef_x    (coef_x),
		.coef_y    (coef_y)
	);

	bqm_axis u_axis_x (
		.clk    (clk),
		.xi_s1  (xi_s1),
		.eta_s1 (eta_s1),
		.coef   (coef_x),
		.res_s5 (res_x_s5)
	);

	bqm_axis u_axis_y (
		.clk    (clk),
		.xi_s1  (xi_s1),
		.eta_s1 (eta_s1),
		.coef   (coef_y),
		.res_s5 (res_y_s5)
	);

	// Result ports come straight from the stage-5 registers.
	assign done        = valid_s5;
	assign phys_x      = res_x_s5.point;
	assign phys_y      = res_y_s5.point;
	assign jac_dx_dxi  = res_x_s5.d_dxi;
	assign jac_dx_deta = res_x_s5.d_deta;
	assign jac_dy_dxi  = res_y_s5.d_dxi;
	assign jac_dy_deta = res_y_s5.d_deta;
	assign saturated   = res_x_s5.pnt_sat | res_x_s5.jac_sat
		| res_y_s5.pnt_sat | res_y_s5.jac_sat;

	// A result strobe always comes from a matching start transfer through all pipeline stages.
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, PIPE_DEPTH))
		else $error("result strobe without a matching start transfer");

	// The mapped point is a convex blend of the corners and never clips.
	a_point_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(res_x_s5.pnt_sat || res_y_s5.pnt_sat))
		else $error("mapped point reported as clipped");

	// A clip flag comes with at least one Jacobian entry at a range limit.
	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |->
			(jac_dx_dxi == COORD_MAX || jac_dx_dxi == COORD_MIN ||
			 jac_dx_deta == COORD_MAX || jac_dx_deta == COORD_MIN ||
			 jac_dy_dxi == COORD_MAX || jac_dy_dxi == COORD_MIN ||
			 jac_dy_deta == COORD_MAX || jac_dy_deta == COORD_MIN))
		else $error("saturated flag without a clipped Jacobian entry");

endmodule

/* tb/sv/quad_map_check_pkg.sv */
// Scoreboard for the bilinear quadrilateral map: bit-exact prediction of the mapped
// point and Jacobian, plus an in-order store of predicted results.
// Depends on bqm_pkg for widths, register indexes and coordinate types.
package quad_map_check_pkg;

	import bqm_pkg::*;

	// Wide enough for any exact sum of weighted corners before rounding.
	typedef logic signed [95:0] wide_sum_t;

	// One predicted or observed result of the block.
	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t dx_dxi;
		coord_t dx_deta;
		coord_t dy_dxi;
		coord_t dy_deta;
		logic   sat;
	} mapped_pt_t;

	localparam int unsigned MAX_REPORTS = 40;

	class quad_map_scoreboard;
		coord_t      corner [NUM_REGS];
		mapped_pt_t  pending_maps [$];
		int unsigned n_points;
		int unsigned n_checked;
		int unsigned n_errors;
		int unsigned n_clipped;

		// Corners come out of reset as the unit square.
		function new();
			corner[REG_C0_X] = COORD_ZERO;
			corner[REG_C0_Y] = COORD_ZERO;
			corner[REG_C1_X] = COORD_ONE;
			corner[REG_C1_Y] = COORD_ZERO;
			corner[REG_C2_X] = COORD_ONE;
			corner[REG_C2_Y] = COORD_ONE;
			corner[REG_C3_X] = COORD_ZERO;
			corner[REG_C3_Y] = COORD_ONE;
			n_points  = 0;
			n_checked = 0;
			n_errors  = 0;
			n_clipped = 0;
		endfunction

		function void write_corner(input logic [REG_IDX_WIDTH-1:0] idx, input coord_t v);
			corner[idx] = v;
		endfunction

		function int unsigned pending_count();
			return pending_maps.size();
		endfunction

		// Reference coordinates above 1.0 are treated as 1.0.
		function longint clip_ref(input ref_t raw);
			longint v;
			longint one;
			one = longint'(1) << FRAC_BITS;
			v   = longint'(raw);
			return (v > one) ? one : v;
		endfunction

		// Drop s fraction bits with round half up, then clip to the coordinate range.
		function coord_t round_clip(input wide_sum_t v, input int unsigned s,
				inout logic sat);
			wide_sum_t sh;
			sh = (v + (wide_sum_t'(1) <<< (s - 1))) >>> s;
			if (sh > wide_sum_t'(COORD_MAX)) begin
				sat = 1'b1;
				return COORD_MAX;
			end
			if (sh < wide_sum_t'(COORD_MIN)) begin
				sat = 1'b1;
				return COORD_MIN;
			end
			return sh[COORD_WIDTH-1:0];
		endfunction

		// Exact bilinear sum of one axis, scaled by two fraction widths.
		function wide_sum_t axis_sum(input longint xi, input longint eta,
				input coord_t c0, input coord_t c1, input coord_t c2, input coord_t c3);
			longint one;
			wide_sum_t acc;
			one = longint'(1) << FRAC_BITS;
			acc = wide_sum_t'((one - xi) * (one - eta)) * wide_sum_t'(longint'(c0))
				+ wide_sum_t'(xi * (one - eta)) * wide_sum_t'(longint'(c1))
				+ wide_sum_t'(xi * eta) * wide_sum_t'(longint'(c2))
				+ wide_sum_t'((one - xi) * eta) * wide_sum_t'(longint'(c3));
			return acc;
		endfunction

		// Linear blend of the edge differences d0 and d1, scaled by 2^FRAC_BITS.
		function wide_sum_t edge_blend(input longint t, input longint d0, input longint d1);
			longint one;
			one = longint'(1) << FRAC_BITS;
			return wide_sum_t'(one - t) * wide_sum_t'(d0) + wide_sum_t'(t) * wide_sum_t'(d1);
		endfunction

		function mapped_pt_t map_point(input ref_t xi_raw, input ref_t eta_raw);
			mapped_pt_t r;
			longint xi;
			longint eta;
			longint cx [4];
			longint cy [4];
			logic sat;
			xi  = clip_ref(xi_raw);
			eta = clip_ref(eta_raw);
			cx[0] = longint'(corner[REG_C0_X]);
			cx[1] = longint'(corner[REG_C1_X]);
			cx[2] = longint'(corner[REG_C2_X]);
			cx[3] = longint'(corner[REG_C3_X]);
			cy[0] = longint'(corner[REG_C0_Y]);
			cy[1] = longint'(corner[REG_C1_Y]);
			cy[2] = longint'(corner[REG_C2_Y]);
			cy[3] = longint'(corner[REG_C3_Y]);
			sat = 1'b0;
			r.x = round_clip(axis_sum(xi, eta, corner[REG_C0_X], corner[REG_C1_X],
				corner[REG_C2_X], corner[REG_C3_X]), 2 * FRAC_BITS, sat);
			r.y = round_clip(axis_sum(xi, eta, corner[REG_C0_Y], corner[REG_C1_Y],
				corner[REG_C2_Y], corner[REG_C3_Y]), 2 * FRAC_BITS, sat);
			r.dx_dxi  = round_clip(edge_blend(eta, cx[1] - cx[0], cx[2] - cx[3]),
				FRAC_BITS, sat);
			r.dx_deta = round_clip(edge_blend(xi, cx[3] - cx[0], cx[2] - cx[1]),
				FRAC_BITS, sat);
			r.dy_dxi  = round_clip(edge_blend(eta, cy[1] - cy[0], cy[2] - cy[3]),
				FRAC_BITS, sat);
			r.dy_deta = round_clip(edge_blend(xi, cy[3] - cy[0], cy[2] - cy[1]),
				FRAC_BITS, sat);
			r.sat = sat;
			return r;
		endfunction

		// Called for every point transfer into the block.
		function void note_point(input ref_t xi, input ref_t eta);
			mapped_pt_t m;
			m = map_point(xi, eta);
			if (m.sat)
				n_clipped++;
			pending_maps.push_back(m);
			n_points++;
		endfunction

		function bit field_ok(input string name, input coord_t want, input coord_t got);
			if (want === got)
				return 1'b1;
			if (n_errors < MAX_REPORTS)
				$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			return 1'b0;
		endfunction

		// Called for every result transfer out of the block.
		function void check_result(input mapped_pt_t got);
			mapped_pt_t want;
			bit ok;
			if (pending_maps.size() == 0) begin
				if (n_errors < MAX_REPORTS)
					$display("%0t: result expected none actual x=%0d y=%0d", $time,
						got.x, got.y);
				n_errors++;
				return;
			end
			want = pending_maps.pop_front();
			ok = 1'b1;
			ok &= field_ok("phys_x", want.x, got.x);
			ok &= field_ok("phys_y", want.y, got.y);
			ok &= field_ok("jac_dx_dxi", want.dx_dxi, got.dx_dxi);
			ok &= field_ok("jac_dx_deta", want.dx_deta, got.dx_deta);
			ok &= field_ok("jac_dy_dxi", want.dy_dxi, got.dy_dxi);
			ok &= field_ok("jac_dy_deta", want.dy_deta, got.dy_deta);
			ok &= field_ok("saturated", coord_t'(want.sat), coord_t'(got.sat));
			if (!ok)
				n_errors++;
			n_checked++;
		endfunction
	endclass

endpackage

/* tb/sv/tb_bilinear_quad_map_with_jacobian_top.sv */
// Testbench top for the bilinear quadrilateral map: drives corner settings and
// reference points, and checks every result against quad_map_check_pkg.
// Depends on bqm_pkg, quad_map_check_pkg and the block's top level.
module tb_bilinear_quad_map_with_jacobian_top;

	import bqm_pkg::*;
	import quad_map_check_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 1000;
	localparam int unsigned RANDOM_PHASES  = 12;
	localparam int unsigned PHASE_POINTS   = 136;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	ref_t                     ref_xi;
	ref_t                     ref_eta;
	logic                     cfg_we;
	logic [REG_IDX_WIDTH-1:0] cfg_idx;
	coord_t                   cfg_wdata;
	logic                     done;
	coord_t                   phys_x;
	coord_t                   phys_y;
	coord_t                   jac_dx_dxi;
	coord_t                   jac_dx_deta;
	coord_t                   jac_dy_dxi;
	coord_t                   jac_dy_deta;
	logic                     saturated;

	quad_map_scoreboard sb;
	int unsigned        idle_cycles = 0;
	int unsigned        n_settings = 1;

	bilinear_quad_map_with_jacobian_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.ref_xi      (ref_xi),
		.ref_eta     (ref_eta),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.done        (done),
		.phys_x      (phys_x),
		.phys_y      (phys_y),
		.jac_dx_dxi  (jac_dx_dxi),
		.jac_dx_deta (jac_dx_deta),
		.jac_dy_dxi  (jac_dy_dxi),
		.jac_dy_deta (jac_dy_deta),
		.saturated   (saturated)
	);

	// Clock with a period of 20.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Observe register writes and both transfer directions at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.write_corner(cfg_idx, cfg_wdata);
			if (start && !busy)
				sb.note_point(ref_xi, ref_eta);
			if (done)
				sb.check_result('{phys_x, phys_y, jac_dx_dxi, jac_dx_deta,
					jac_dy_dxi, jac_dy_deta, saturated});
		end
	end

	// Stop the run if no transfer or write happens for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || cfg_we)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired with %0d results outstanding", $time,
					sb.pending_count());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Offer one point and hold it until the block takes it.
	task automatic send_point(input ref_t xi, input ref_t eta);
		@(negedge clk);
		start   <= 1'b1;
		ref_xi  <= xi;
		ref_eta <= eta;
		do @(posedge clk); while (busy);
	endtask

	// Sender gap: start low, junk on the point inputs.
	task automatic hold_off(input int unsigned n);
		repeat (n) begin
			@(negedge clk);
			start   <= 1'b0;
			ref_xi  <= ref_t'($urandom);
			ref_eta <= ref_t'($urandom);
		end
	endtask

	// Stop sending and wait until every predicted result has been checked.
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending_count() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_WIDTH-1:0] idx, input coord_t v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= v;
		@(posedge clk);
	endtask

	// Load all four corners; only called while the pipeline is empty.
	task automatic load_quad(input coord_t x0, input coord_t y0, input coord_t x1,
			input coord_t y1, input coord_t x2, input coord_t y2, input coord_t x3,
			input coord_t y3);
		write_reg(REG_C0_X, x0);
		write_reg(REG_C0_Y, y0);
		write_reg(REG_C1_X, x1);
		write_reg(REG_C1_Y, y1);
		write_reg(REG_C2_X, x2);
		write_reg(REG_C2_Y, y2);
		write_reg(REG_C3_X, x3);
		write_reg(REG_C3_Y, y3);
		@(negedge clk);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// Reference coordinate: mostly inside the unit range, with edges and clipping.
	function automatic ref_t rand_ref();
		case ($urandom_range(0, 15))
			0:       return ref_t'(0);
			1:       return REF_ONE;
			2, 3:    return ref_t'($urandom_range(REF_ONE + 1, (1 << REF_WIDTH) - 1));
			4:       return ref_t'($urandom_range(0, 15));
			5:       return ref_t'($urandom_range(REF_ONE - 15, REF_ONE));
			default: return ref_t'($urandom_range(0, REF_ONE));
		endcase
	endfunction

	// Corner value: small quads of a few units, or anything up to the extremes.
	function automatic coord_t rand_corner(input bit wide);
		int unsigned pick;
		pick = wide ? $urandom_range(0, 7) : 3;
		case (pick)
			0:       return COORD_MIN;
			1:       return COORD_MAX;
			2:       return COORD_ZERO;
			3, 4:    return coord_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
			default: return coord_t'($urandom);
		endcase
	endfunction

	initial begin
		int unsigned left;
		int unsigned burst;
		bit          wide;
		bit          gappy;

		sb        = new();
		arst_n    = 1'b0;
		start     = 1'b0;
		ref_xi    = '0;
		ref_eta   = '0;
		cfg_we    = 1'b0;
		cfg_idx   = REG_C0_X;
		cfg_wdata = COORD_ZERO;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Unit square out of reset: corners, center and clipped coordinates.
		send_point(ref_t'(0), ref_t'(0));
		send_point(REF_ONE, ref_t'(0));
		send_point(REF_ONE, REF_ONE);
		send_point(ref_t'(0), REF_ONE);
		send_point(REF_ONE >> 1, REF_ONE >> 1);
		send_point(ref_t'((1 << REF_WIDTH) - 1), ref_t'((1 << REF_WIDTH) - 1));
		send_point(REF_ONE + 1, ref_t'(1));
		send_point(ref_t'(1), REF_ONE + 1);
		drain();

		// Corners one LSB apart so the center lands on rounding ties.
		load_quad(coord_t'(1), coord_t'(-1), COORD_ZERO, COORD_ZERO,
			coord_t'(1), coord_t'(-1), COORD_ZERO, COORD_ZERO);
		send_point(REF_ONE >> 1, REF_ONE >> 1);
		send_point(REF_ONE >> 2, REF_ONE >> 1);
		send_point(REF_ONE >> 1, ref_t'(0));
		drain();

		// Opposite extremes: edge differences overflow and the Jacobian clips.
		load_quad(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN);
		send_point(ref_t'(0), ref_t'(0));
		send_point(REF_ONE, REF_ONE);
		send_point(REF_ONE >> 1, REF_ONE >> 1);
		send_point(ref_t'(0), REF_ONE);
		send_point(REF_ONE, ref_t'(0));
		send_point(ref_t'(1), REF_ONE - 1);
		drain();

		// Random corner settings, each followed by a stream of random points.
		for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
			wide  = (phase % 3) == 2;
			gappy = (phase % 4) != 0;
			load_quad(rand_corner(wide), rand_corner(wide), rand_corner(wide),
				rand_corner(wide), rand_corner(wide), rand_corner(wide),
				rand_corner(wide), rand_corner(wide));
			left = PHASE_POINTS;
			while (left > 0) begin
				burst = $urandom_range(1, 24);
				while (burst > 0 && left > 0) begin
					send_point(rand_ref(), rand_ref());
					burst--;
					left--;
				end
				if (gappy)
					hold_off($urandom_range(1, 9));
			end
			drain();
		end

		// Let any stray result show up before the verdict.
		repeat (2 * PIPE_DEPTH) @(posedge clk);
		$display("Mapped %0d points over %0d corner settings, %0d of them with a clipped value.",
			sb.n_points, n_settings, sb.n_clipped);
		$display("Checked %0d results, %0d with errors.", sb.n_checked, sb.n_errors);
		if (sb.n_errors == 0 && sb.pending_count() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* bilinear_quad_map_with_jacobian_top.f */
hw/rtl/bqm_pkg.sv
hw/rtl/bqm_cfg.sv
hw/rtl/bqm_axis.sv
hw/rtl/bilinear_quad_map_with_jacobian_top.sv
tb/sv/quad_map_check_pkg.sv
tb/sv/tb_bilinear_quad_map_with_jacobian_top.sv
